/* sv/dalme_pkg.sv */
// Shared types, constants and helpers for the dual-axis lens move encoder.
package dalme_pkg;

    localparam int unsigned STEP_W  = 12;
    localparam int unsigned RATE_W  = 14;
    localparam int unsigned CLK_W   = 26;
    localparam int unsigned WAIT_W  = 17;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [RATE_W-1:0] PPS_MIN = 14'd32;
    localparam logic [RATE_W-1:0] PPS_MAX = 14'd16383;
    localparam logic [9:0]        MS_PER_S = 10'd1000;

    localparam logic [CLK_W-1:0]  REF_CLOCK_RST = 26'd24000000;
    localparam logic [7:0]        SETTLE_RST    = 8'd40;
    localparam logic [STEP_W-1:0] MAX_CHUNK_RST = 12'd3500;

    // configuration register indexes
    localparam logic [1:0] CFG_REF_CLOCK = 2'd0;
    localparam logic [1:0] CFG_SETTLE    = 2'd1;
    localparam logic [1:0] CFG_MAX_CHUNK = 2'd2;

    // driver register addresses
    localparam logic [7:0] ADDR_WAKE    = 8'h00;
    localparam logic [7:0] ADDR_F_SPD_L = 8'h01;
    localparam logic [7:0] ADDR_F_SPD_H = 8'h02;
    localparam logic [7:0] ADDR_F_STP_L = 8'h03;
    localparam logic [7:0] ADDR_F_STP_H = 8'h04;
    localparam logic [7:0] ADDR_Z_SPD_L = 8'h05;
    localparam logic [7:0] ADDR_Z_SPD_H = 8'h06;
    localparam logic [7:0] ADDR_Z_STP_L = 8'h07;
    localparam logic [7:0] ADDR_Z_STP_H = 8'h08;
    localparam logic [7:0] ADDR_TRIG    = 8'h09;
    localparam logic [7:0] ADDR_EXCITE  = 8'h0A;

    localparam logic [7:0] VAL_WAKE    = 8'h01;
    localparam logic [7:0] VAL_EXCITE  = 8'h08;
    localparam logic [7:0] VAL_OFF     = 8'h00;
    localparam logic [7:0] SPD_H_MARK  = 8'h80;
    localparam logic [7:0] DIR_SET     = 8'hC0;
    localparam logic [7:0] DIR_CLR     = 8'h80;
    localparam logic [7:0] TRIG_BOTH   = 8'hCF;
    localparam logic [7:0] TRIG_FOCUS  = 8'h8F;
    localparam logic [7:0] TRIG_ZOOM   = 8'h4F;

    localparam logic [3:0] LAST_WRITE_IDX = 4'd12;

    // one classified move request
    typedef struct packed {
        logic [STEP_W-1:0] zoom_steps;
        logic              zoom_dir;
        logic [STEP_W-1:0] focus_steps;
        logic              focus_dir;
        logic [RATE_W-1:0] base;
        logic [STEP_W-1:0] longest_steps;
    } move_t;

    // divider operation codes
    typedef enum logic [2:0] {
        OP_RATE_Z  = 3'd0,
        OP_RATE_F  = 3'd1,
        OP_DIV_F   = 3'd2,
        OP_DIV_Z   = 3'd3,
        OP_TIME_Z  = 3'd4,
        OP_TIME_F  = 3'd5
    } div_op_t;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [CLK_W-1:0] r);
        logic [RATE_W-1:0] res;
        if (r < CLK_W'(PPS_MIN))
            res = PPS_MIN;
        else if (r > CLK_W'(PPS_MAX))
            res = PPS_MAX;
        else
            res = r[RATE_W-1:0];
        return res;
    endfunction

endpackage

/* sv/dalme_front.sv */
// Front end: clamps a move request and drops empty moves.
module dalme_front (
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [11:0]              zoom_steps,
    input  logic                     zoom_dir,
    input  logic [11:0]              focus_steps,
    input  logic                     focus_dir,
    input  logic [15:0]              base_rate,
    input  logic [11:0]              max_chunk,
    input  logic                     q_full,
    output logic                     q_push,
    output dalme_pkg::move_t         q_data
);
    import dalme_pkg::*;

    logic [STEP_W-1:0] zs;
    logic [STEP_W-1:0] fs;
    logic [RATE_W-1:0] base_c;

    // clamp the step counts to the chunk limit
    assign zs = (zoom_steps > max_chunk) ? max_chunk : zoom_steps;
    assign fs = (focus_steps > max_chunk) ? max_chunk : focus_steps;

    // clamp the base rate
    assign base_c = (base_rate < 16'(PPS_MIN)) ? PPS_MIN :
                    (base_rate > 16'(PPS_MAX)) ? PPS_MAX : base_rate[RATE_W-1:0];

    assign in_ready = !q_full;

    // push only moves that actually step
    assign q_push = in_valid && !q_full && ((zs != '0) || (fs != '0));

    always_comb
    begin
        q_data.zoom_steps    = zs;
        q_data.zoom_dir      = zoom_dir;
        q_data.focus_steps   = fs;
        q_data.focus_dir     = focus_dir;
        q_data.base          = base_c;
        q_data.longest_steps = (zs > fs) ? zs : fs;
    end

endmodule

/* sv/dalme_queue.sv */
// Two-entry queue between the front end and the sequencer.
module dalme_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dalme_pkg::move_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output dalme_pkg::move_t pop_data
);
    import dalme_pkg::*;

    move_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold request data
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* sv/dalme_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module dalme_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [25:0] dividend,
    input  logic [13:0] divisor,
    output logic        done,
    output logic [25:0] quotient
);
    import dalme_pkg::*;

    logic [CLK_W-1:0]  quo_reg, quo_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0] dvs_reg;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RATE_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[CLK_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // shift one dividend bit into the remainder per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[CLK_W-2:0], fits};
            rem_next = fits ? RATE_W'(trial - {1'b0, dvs_reg}) : trial[RATE_W-1:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(CLK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/dalme_back.sv */
// Back end: computes rates, dividers and wait time, then emits the write sequence.
module dalme_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  dalme_pkg::move_t q_data,
    output logic             q_pop,
    input  logic [25:0]      ref_clock,
    input  logic [7:0]       settle,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       reg_addr,
    output logic [7:0]       reg_value,
    output logic [16:0]      wait_before_ms,
    output logic             last_write
);
    import dalme_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    div_op_t           op_reg, op_next;
    logic [3:0]        idx_reg, idx_next;
    move_t             job_reg;
    logic [RATE_W-1:0] rz_reg, rf_reg;
    logic [CLK_W-1:0]  divz_reg, divf_reg;
    logic [WAIT_W-1:0] tz_reg, wait_reg;

    logic              div_start, div_done;
    logic [CLK_W-1:0]  div_dividend, div_q;
    logic [RATE_W-1:0] div_divisor;
    logic [WAIT_W-1:0] tf;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        addr_reg, value_reg;
    logic [WAIT_W-1:0] owait_reg;
    logic              olast_reg;
    logic              load;
    logic [7:0]        e_addr, e_value, trig;
    logic [WAIT_W-1:0] e_wait;

    dalme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // select divider operands for the current operation
    always_comb
    begin
        div_dividend = '0;
        div_divisor  = RATE_W'(job_reg.longest_steps);
        unique case (op_reg)
            OP_RATE_Z:
            begin
                div_dividend = CLK_W'(job_reg.base) * CLK_W'(job_reg.zoom_steps);
                div_divisor  = RATE_W'(job_reg.longest_steps);
            end
            OP_RATE_F:
            begin
                div_dividend = CLK_W'(job_reg.base) * CLK_W'(job_reg.focus_steps);
                div_divisor  = RATE_W'(job_reg.longest_steps);
            end
            OP_DIV_F:
            begin
                div_dividend = ref_clock;
                div_divisor  = rf_reg;
            end
            OP_DIV_Z:
            begin
                div_dividend = ref_clock;
                div_divisor  = rz_reg;
            end
            OP_TIME_Z:
            begin
                div_dividend = CLK_W'(job_reg.zoom_steps) * CLK_W'(MS_PER_S);
                div_divisor  = rz_reg;
            end
            OP_TIME_F:
            begin
                div_dividend = CLK_W'(job_reg.focus_steps) * CLK_W'(MS_PER_S);
                div_divisor  = rf_reg;
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    assign div_start = (state_reg == S_START);
    assign tf        = div_q[WAIT_W-1:0];
    assign load      = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;

    // sequence the divisions, then the writes
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    op_next    = OP_RATE_Z;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_TIME_F)
                    begin
                        idx_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        op_next    = div_op_t'(op_reg + 3'd1);
                        state_next = S_START;
                    end
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == LAST_WRITE_IDX)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_RATE_Z;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the job and the division results
    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_data;
        if ((state_reg == S_WAIT) && div_done)
        begin
            unique case (op_reg)
                OP_RATE_Z:
                    rz_reg <= (job_reg.zoom_steps == '0) ? job_reg.base : clamp_rate(div_q);
                OP_RATE_F:
                    rf_reg <= (job_reg.focus_steps == '0) ? job_reg.base : clamp_rate(div_q);
                OP_DIV_F:
                    divf_reg <= div_q;
                OP_DIV_Z:
                    divz_reg <= div_q;
                OP_TIME_Z:
                    tz_reg <= div_q[WAIT_W-1:0];
                OP_TIME_F:
                    wait_reg <= ((tz_reg > tf) ? tz_reg : tf) + WAIT_W'(settle);
                default:
                    tz_reg <= tz_reg;
            endcase
        end
    end

    // trigger code from which axes move
    assign trig = (job_reg.zoom_steps == '0)  ? TRIG_FOCUS :
                  (job_reg.focus_steps == '0) ? TRIG_ZOOM  : TRIG_BOTH;

    // pick the write for the current slot
    always_comb
    begin
        e_addr  = ADDR_WAKE;
        e_value = VAL_OFF;
        e_wait  = '0;
        unique case (idx_reg)
            4'd0:  begin e_addr = ADDR_WAKE;    e_value = VAL_WAKE; end
            4'd1:  begin e_addr = ADDR_EXCITE;  e_value = VAL_EXCITE; end
            4'd2:  begin e_addr = ADDR_F_SPD_L; e_value = divf_reg[14:7]; end
            4'd3:  begin e_addr = ADDR_F_SPD_H; e_value = SPD_H_MARK | divf_reg[22:15]; end
            4'd4:  begin e_addr = ADDR_Z_SPD_L; e_value = divz_reg[14:7]; end
            4'd5:  begin e_addr = ADDR_Z_SPD_H; e_value = SPD_H_MARK | divz_reg[22:15]; end
            4'd6:  begin e_addr = ADDR_F_STP_L; e_value = job_reg.focus_steps[7:0]; end
            4'd7:
            begin
                e_addr  = ADDR_F_STP_H;
                e_value = (job_reg.focus_dir ? DIR_CLR : DIR_SET)
                          | {4'd0, job_reg.focus_steps[11:8]};
            end
            4'd8:  begin e_addr = ADDR_Z_STP_L; e_value = job_reg.zoom_steps[7:0]; end
            4'd9:
            begin
                e_addr  = ADDR_Z_STP_H;
                e_value = (job_reg.zoom_dir ? DIR_SET : DIR_CLR)
                          | {4'd0, job_reg.zoom_steps[11:8]};
            end
            4'd10: begin e_addr = ADDR_TRIG;    e_value = trig; end
            4'd11: begin e_addr = ADDR_EXCITE;  e_value = VAL_OFF; e_wait = wait_reg; end
            default:
            begin
                e_addr  = ADDR_WAKE;
                e_value = VAL_OFF;
            end
        endcase
    end

    // output register: load when empty or being taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = (state_reg == S_EMIT);
    end

    always_ff @(posedge clk)
    begin
        if (load && (state_reg == S_EMIT))
        begin
            addr_reg  <= e_addr;
            value_reg <= e_value;
            owait_reg <= e_wait;
            olast_reg <= (idx_reg == LAST_WRITE_IDX);
        end
    end

    assign out_valid      = out_valid_reg;
    assign reg_addr       = addr_reg;
    assign reg_value      = value_reg;
    assign wait_before_ms = owait_reg;
    assign last_write     = olast_reg;

endmodule

/* sv/dual_axis_lens_move_encoder.sv */
// Top level of the dual-axis lens move encoder.
// Input channel (in_valid/in_ready) takes one move request: zoom and focus
// step counts and directions plus a base pulse rate. Output channel
// (out_valid/out_ready) delivers the driver register writes for that move,
// thirteen of them, the final one flagged by last_write. A move where both
// clamped step counts are zero produces no writes.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 reference clock, 1 settle time, 2 chunk limit); write only while idle.
// One shared bit-serial divider runs six divisions per move (two axis
// rates, two speed dividers, two move times), each started and handed off
// in turn by the sequencer, then the thirteen writes leave at one per
// cycle while the receiver keeps out_ready high.
// A two-entry queue accepts further requests meanwhile.
// Reset clears the queue, sequencer and output register and restores the
// default configuration. When the receiver stalls, the held write stays on
// the outputs and the sequencer waits; the queue keeps taking requests
// until it is full.
module dual_axis_lens_move_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [25:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] zoom_steps,
    input  logic        zoom_dir,
    input  logic [11:0] focus_steps,
    input  logic        focus_dir,
    input  logic [15:0] base_rate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  reg_addr,
    output logic [7:0]  reg_value,
    output logic [16:0] wait_before_ms,
    output logic        last_write
);
    import dalme_pkg::*;

    logic [CLK_W-1:0]  ref_clock_reg;
    logic [7:0]        settle_reg;
    logic [STEP_W-1:0] max_chunk_reg;

    logic  q_full, q_push, q_pop, q_not_empty;
    move_t q_in, q_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_clock_reg <= REF_CLOCK_RST;
            settle_reg    <= SETTLE_RST;
            max_chunk_reg <= MAX_CHUNK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REF_CLOCK: ref_clock_reg <= cfg_data;
                CFG_SETTLE:    settle_reg    <= cfg_data[7:0];
                CFG_MAX_CHUNK: max_chunk_reg <= cfg_data[STEP_W-1:0];
                default:       ref_clock_reg <= ref_clock_reg;
            endcase
        end
    end

    dalme_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .zoom_steps  (zoom_steps),
        .zoom_dir    (zoom_dir),
        .focus_steps (focus_steps),
        .focus_dir   (focus_dir),
        .base_rate   (base_rate),
        .max_chunk   (max_chunk_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    dalme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    dalme_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .ref_clock      (ref_clock_reg),
        .settle         (settle_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_addr       (reg_addr),
        .reg_value      (reg_value),
        .wait_before_ms (wait_before_ms),
        .last_write     (last_write)
    );

    // the final write of a move is the power-off of the wake register
    a_last_is_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_write |-> (reg_addr == ADDR_WAKE) && (reg_value == VAL_OFF))
        else $error("last write is not the power-off write");

    // a wait only ever rides on the coil power-off write
    a_wait_on_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (wait_before_ms != '0) |-> (reg_addr == ADDR_EXCITE)
            && (reg_value == VAL_OFF))
        else $error("wait attached to the wrong write");

    // a taken last write is never followed at once by another last write
    a_no_double_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_write |=> !(out_valid && last_write))
        else $error("repeated last write");

endmodule
